// File: rtl/hsrm_pkg.sv
// Shared types and constants for the HLS skin range mask.
// Used by the configuration registers, the reference lanes and the top level.
// No dependencies.
package hsrm_pkg;

    // Table geometry and field widths
    localparam int ENTRIES_DEFAULT = 16;
    localparam int CHAN_W          = 8;
    localparam int TOL_W           = 7;
    localparam int IDX_W           = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 5;

    // Operation codes carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_HUE_BELOW   = 3'd0,
        REG_HUE_ABOVE   = 3'd1,
        REG_LIGHT_BELOW = 3'd2,
        REG_LIGHT_ABOVE = 3'd3,
        REG_SAT_BELOW   = 3'd4,
        REG_SAT_ABOVE   = 3'd5
    } t_reg_idx;

    // Reset values of the tolerances
    localparam logic [TOL_W-1:0] RST_HUE_BELOW   = 7'd100;
    localparam logic [TOL_W-1:0] RST_HUE_ABOVE   = 7'd53;
    localparam logic [TOL_W-1:0] RST_LIGHT_BELOW = 7'd31;
    localparam logic [TOL_W-1:0] RST_LIGHT_ABOVE = 7'd91;
    localparam logic [TOL_W-1:0] RST_SAT_BELOW   = 7'd36;
    localparam logic [TOL_W-1:0] RST_SAT_ABOVE   = 7'd100;

    // One colour in HLS order
    typedef struct packed {
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] lightness;
        logic [CHAN_W-1:0] hue;
    } t_color;

    // Window tolerances handed from the register block to every lane
    typedef struct packed {
        logic [TOL_W-1:0] hue_below;
        logic [TOL_W-1:0] hue_above;
        logic [TOL_W-1:0] light_below;
        logic [TOL_W-1:0] light_above;
        logic [TOL_W-1:0] sat_below;
        logic [TOL_W-1:0] sat_above;
    } t_tol;

endpackage

// File: rtl/hls_skin_range_mask.sv
// Top level of the HLS skin range mask: input register, reference lanes,
// result register. Depends on hsrm_pkg, hsrm_cfg_regs and hsrm_lane.
//
// Usage:
//   s_axis carries load and pixel items. tuser is the operation (0 load,
//   1 pixel). A load writes the colour in tdata into entry entry_index
//   (indexes of ENTRIES or more are dropped) and gives no result. A pixel
//   is compared with every entry in parallel and gives one transfer on
//   m_axis with in_mask in tdata bit 0.
//   The APB port sets the six tolerances at byte addresses 0..20; pready is
//   always high and writes are meant for idle periods only.
// Flow:
//   One item is taken every cycle while m_axis does not stall. A pixel result
//   passes the input register, then the result register, before it is on
//   m_axis; a load passes the input register and then lands in the table,
//   in time for the next pixel.
// Reset:
//   Clears the table to zero, restores the tolerances, empties both stages.
// Stall:
//   While a result waits on m_axis the pipeline holds; s_axis_tready stays
//   high while the input register is empty or can move on, so two items are
//   held before the input stalls.
module hls_skin_range_mask #(
    parameter int ENTRIES = hsrm_pkg::ENTRIES_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [3:0] entry_index, [11:4] hue, [19:12] lightness,
    //        [27:20] saturation, [31:28] zero
    input  logic [31:0]                      s_axis_tdata,
    // tuser: [0] operation
    input  logic                             s_axis_tuser,
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [0] in_mask, [7:1] zero
    output logic [7:0]                       m_axis_tdata,
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsrm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [hsrm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [hsrm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    hsrm_pkg::t_tol   tol;

    // Input stage
    logic                       r_in_valid;
    logic                       r_in_op;
    logic [hsrm_pkg::IDX_W-1:0] r_in_idx;
    hsrm_pkg::t_color           r_in_color;

    // Result stage
    logic                       r_out_valid;
    logic                       r_out_mask;

    logic                       advance;
    logic                       in_xfer;
    logic                       load_commit;
    logic [ENTRIES-1:0]         lane_wr;
    logic [ENTRIES-1:0]         lane_hit;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign load_commit   = advance && r_in_valid && (r_in_op == hsrm_pkg::OP_LOAD);

    hsrm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tol   (tol)
    );

    // Capture a transfer into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op               <= s_axis_tuser;
            r_in_idx              <= s_axis_tdata[3:0];
            r_in_color.hue        <= s_axis_tdata[11:4];
            r_in_color.lightness  <= s_axis_tdata[19:12];
            r_in_color.saturation <= s_axis_tdata[27:20];
        end
    end

    // One lane per table entry
    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        assign lane_wr[g] = load_commit && (int'(r_in_idx) == g);

        hsrm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr_en (lane_wr[g]),
            .i_pixel (r_in_color),
            .i_tol   (tol),
            .o_hit   (lane_hit[g])
        );
    end

    // Advance pixel results into the result register; loads leave nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && (r_in_op == hsrm_pkg::OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mask <= |lane_hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_mask};

endmodule

// File: rtl/hsrm_cfg_regs.sv
// APB-style register block holding the six window tolerances.
// Depends on hsrm_pkg.
module hsrm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsrm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [hsrm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [hsrm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output hsrm_pkg::t_tol                   o_tol
);

    hsrm_pkg::t_tol      r_tol;
    hsrm_pkg::t_reg_idx  reg_sel;
    logic                wr_en;
    logic [hsrm_pkg::TOL_W-1:0] wr_val;
    logic [hsrm_pkg::TOL_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_sel = hsrm_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign wr_val  = pwdata[hsrm_pkg::TOL_W-1:0];

    // Write the addressed tolerance; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol.hue_below   <= hsrm_pkg::RST_HUE_BELOW;
            r_tol.hue_above   <= hsrm_pkg::RST_HUE_ABOVE;
            r_tol.light_below <= hsrm_pkg::RST_LIGHT_BELOW;
            r_tol.light_above <= hsrm_pkg::RST_LIGHT_ABOVE;
            r_tol.sat_below   <= hsrm_pkg::RST_SAT_BELOW;
            r_tol.sat_above   <= hsrm_pkg::RST_SAT_ABOVE;
        end else if (wr_en) begin
            case (reg_sel)
                hsrm_pkg::REG_HUE_BELOW:   r_tol.hue_below   <= wr_val;
                hsrm_pkg::REG_HUE_ABOVE:   r_tol.hue_above   <= wr_val;
                hsrm_pkg::REG_LIGHT_BELOW: r_tol.light_below <= wr_val;
                hsrm_pkg::REG_LIGHT_ABOVE: r_tol.light_above <= wr_val;
                hsrm_pkg::REG_SAT_BELOW:   r_tol.sat_below   <= wr_val;
                hsrm_pkg::REG_SAT_ABOVE:   r_tol.sat_above   <= wr_val;
                default: ;
            endcase
        end
    end

    // Read back the addressed tolerance, zero for unknown indexes
    always_comb begin
        case (reg_sel)
            hsrm_pkg::REG_HUE_BELOW:   rd_val = r_tol.hue_below;
            hsrm_pkg::REG_HUE_ABOVE:   rd_val = r_tol.hue_above;
            hsrm_pkg::REG_LIGHT_BELOW: rd_val = r_tol.light_below;
            hsrm_pkg::REG_LIGHT_ABOVE: rd_val = r_tol.light_above;
            hsrm_pkg::REG_SAT_BELOW:   rd_val = r_tol.sat_below;
            hsrm_pkg::REG_SAT_ABOVE:   rd_val = r_tol.sat_above;
            default:                   rd_val = '0;
        endcase
    end

    assign prdata = {{(hsrm_pkg::CFG_DATA_W - hsrm_pkg::TOL_W){1'b0}}, rd_val};
    assign o_tol  = r_tol;

endmodule

// File: rtl/hsrm_lane.sv
// One reference colour entry and its window compare against the current pixel.
// Depends on hsrm_pkg.
module hsrm_lane (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  hsrm_pkg::t_color i_pixel,
    input  hsrm_pkg::t_tol   i_tol,
    output logic             o_hit
);

    hsrm_pkg::t_color r_mean;
    logic hit_h;
    logic hit_l;
    logic hit_s;

    // Inside [max(mean-below,0), min(mean+above,255)]; clamps drop out since
    // the pixel value is itself within 0..255
    function automatic logic in_window(
        input logic [hsrm_pkg::CHAN_W-1:0] v,
        input logic [hsrm_pkg::CHAN_W-1:0] mean,
        input logic [hsrm_pkg::TOL_W-1:0]  below,
        input logic [hsrm_pkg::TOL_W-1:0]  above
    );
        logic [hsrm_pkg::CHAN_W:0] v_ext;
        logic [hsrm_pkg::CHAN_W:0] m_ext;
        logic [hsrm_pkg::CHAN_W:0] lo_ok_sum;
        logic [hsrm_pkg::CHAN_W:0] hi_sum;
        v_ext     = {1'b0, v};
        m_ext     = {1'b0, mean};
        lo_ok_sum = v_ext + (hsrm_pkg::CHAN_W+1)'(below);
        hi_sum    = m_ext + (hsrm_pkg::CHAN_W+1)'(above);
        return (lo_ok_sum >= m_ext) && (v_ext <= hi_sum);
    endfunction

    // Hold the entry; the pixel bus carries the new mean on a load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (i_wr_en) begin
            r_mean <= i_pixel;
        end
    end

    assign hit_h = in_window(i_pixel.hue, r_mean.hue, i_tol.hue_below, i_tol.hue_above);
    assign hit_l = in_window(i_pixel.lightness, r_mean.lightness,
                             i_tol.light_below, i_tol.light_above);
    assign hit_s = in_window(i_pixel.saturation, r_mean.saturation,
                             i_tol.sat_below, i_tol.sat_above);
    assign o_hit = hit_h & hit_l & hit_s;

endmodule
